// ===== rtl/itmd_pkg.sv =====
// Package for the inline text markup decoder.
// Holds the beat payload types, the configuration register map and the character constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itmd_pkg;

    localparam int CHAR_BITS  = 16;
    localparam int SIZE_SLOTS = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_FACE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ALPHA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MAP     = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_START_FACE   = 16'hFFFF;
    localparam logic [15:0] RST_START_BORDER = 16'h0000;
    localparam logic [7:0]  RST_START_ALPHA  = 8'hFF;
    localparam logic [2:0]  RST_START_SIZE   = 3'd0;
    localparam logic [1:0]  RST_FONT_COUNT   = 2'd3;
    localparam logic [8:0]  RST_SIZE_MAP     = 9'd136;

    // Characters with a meaning to the parser.
    localparam logic [CHAR_BITS-1:0] CH_HASH = CHAR_BITS'(8'h23);
    localparam logic [CHAR_BITS-1:0] CH_I    = CHAR_BITS'(8'h49);
    localparam logic [CHAR_BITS-1:0] CH_A    = CHAR_BITS'(8'h41);
    localparam logic [CHAR_BITS-1:0] CH_S    = CHAR_BITS'(8'h53);
    localparam logic [CHAR_BITS-1:0] CH_F    = CHAR_BITS'(8'h46);
    localparam logic [CHAR_BITS-1:0] CH_B    = CHAR_BITS'(8'h42);
    localparam logic [CHAR_BITS-1:0] CH_CR   = CHAR_BITS'(8'h0D);
    localparam logic [CHAR_BITS-1:0] CH_0    = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0] CH_9    = CHAR_BITS'(8'h39);

    localparam logic ITEM_GLYPH  = 1'b0;
    localparam logic ITEM_SPRITE = 1'b1;

    typedef struct packed {
        logic [15:0] start_face_color;
        logic [15:0] start_border_color;
        logic [7:0]  start_alpha;
        logic [2:0]  start_font_size;
        logic [1:0]  font_count;
        logic [8:0]  size_map;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 text_start;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] item_code;
        logic [2:0]  font_size;
        logic [15:0] face_color;
        logic [15:0] border_color;
        logic [7:0]  alpha;
        logic        size_fault;
    } t_out_item;

    // Upper-case hex digit value; anything else counts as zero.
    function automatic logic [3:0] hex_value(input logic [CHAR_BITS-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c[3:0];
        end else if (c >= CH_A && c <= CH_F) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Three 4-bit components packed into RGB565 positions.
    function automatic logic [15:0] rgb_pack(input logic [11:0] v);
        return {v[11:8], 1'b0, v[7:4], 2'b00, v[3:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/inline_text_markup_decoder.sv =====
// Inline text markup decoder: one text character per input beat, glyph or sprite beats out.
// Uses itmd_pkg, itmd_cfg, itmd_parse and itmd_outq.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one character per beat,
// with text_start marking the first character of a text. Output channel (o_out_valid /
// i_out_ready / o_out_item) carries glyphs and sprites with the attributes in force.
// Markup characters, carriage returns and digits other than a sprite's last give no beat.
// The configuration port writes one register per cycle with i_cfg_wr_en; new start values
// take effect at the next text start.
// A result beat is written into the result queue when its character is accepted.
// One character per cycle while o_in_ready is high, with combinational parser next state.
// A two-entry result queue decouples the sides, so a character is accepted while one
// result still waits; o_in_ready drops only when both queue entries are occupied.
// Reset (i_rst_n low, synchronous) restores register defaults, returns the parser to idle
// with the default attributes, and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none

module inline_text_markup_decoder
    import itmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item
);

    t_cfg      cfg;
    t_out_item res_item;
    logic      res_push;
    logic      q_full;
    logic      fire;

    assign o_in_ready = !q_full;
    assign fire       = i_in_valid && o_in_ready;

    itmd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    itmd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_item  (i_in_item),
        .o_push  (res_push),
        .o_item  (res_item)
    );

    itmd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && res_push),
        .i_item  (res_item),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/itmd_cfg.sv =====
// Configuration register file of the inline text markup decoder.
// Uses itmd_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module itmd_cfg
    import itmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_face_color   <= RST_START_FACE;
            r_cfg.start_border_color <= RST_START_BORDER;
            r_cfg.start_alpha        <= RST_START_ALPHA;
            r_cfg.start_font_size    <= RST_START_SIZE;
            r_cfg.font_count         <= RST_FONT_COUNT;
            r_cfg.size_map           <= RST_SIZE_MAP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_START_FACE:   r_cfg.start_face_color   <= i_cfg_wdata;
                REG_START_BORDER: r_cfg.start_border_color <= i_cfg_wdata;
                REG_START_ALPHA:  r_cfg.start_alpha        <= i_cfg_wdata[7:0];
                REG_START_SIZE:   r_cfg.start_font_size    <= i_cfg_wdata[2:0];
                REG_FONT_COUNT:   r_cfg.font_count         <= i_cfg_wdata[1:0];
                REG_SIZE_MAP:     r_cfg.size_map           <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/itmd_parse.sv =====
// Markup parser: holds parse state and current attributes, decodes one character per beat.
// Uses itmd_pkg for payload types, character constants and helper functions.
`timescale 1ns / 1ps
`default_nettype none

module itmd_parse
    import itmd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output logic           o_push,
    output t_out_item      o_item
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HASH   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CMD_I = 3'd0,
        CMD_A = 3'd1,
        CMD_S = 3'd2,
        CMD_F = 3'd3,
        CMD_B = 3'd4
    } t_cmd;

    t_phase      r_phase, n_phase, s_phase;
    t_cmd        r_cmd, n_cmd, s_cmd;
    logic [2:0]  r_left, n_left, s_left;
    logic [15:0] r_acc, n_acc, s_acc;
    logic [15:0] r_face, n_face, s_face;
    logic [15:0] r_border, n_border, s_border;
    logic [7:0]  r_alpha, n_alpha, s_alpha;
    logic [2:0]  r_size, n_size, s_size;
    logic        r_fault, n_fault, s_fault;

    logic [CHAR_BITS-1:0] c;
    logic [3:0]           idx;
    logic                 plain;

    assign c   = i_item.char_code;
    // The size index is the single digit of the size command.
    assign idx = hex_value(c);

    // Start-of-text restore applies before the character is decoded.
    always_comb begin
        if (i_item.text_start) begin
            s_phase  = PH_IDLE;
            s_cmd    = CMD_I;
            s_left   = 3'd0;
            s_acc    = 16'd0;
            s_face   = i_cfg.start_face_color;
            s_border = i_cfg.start_border_color;
            s_alpha  = i_cfg.start_alpha;
            s_size   = i_cfg.start_font_size;
            s_fault  = 1'b0;
        end else begin
            s_phase  = r_phase;
            s_cmd    = r_cmd;
            s_left   = r_left;
            s_acc    = r_acc;
            s_face   = r_face;
            s_border = r_border;
            s_alpha  = r_alpha;
            s_size   = r_size;
            s_fault  = r_fault;
        end
    end

    always_comb begin
        n_phase  = s_phase;
        n_cmd    = s_cmd;
        n_left   = s_left;
        n_acc    = s_acc;
        n_face   = s_face;
        n_border = s_border;
        n_alpha  = s_alpha;
        n_size   = s_size;
        n_fault  = s_fault;
        o_push   = 1'b0;
        plain    = 1'b0;

        o_item.item_kind    = ITEM_GLYPH;
        o_item.item_code    = c[15:0];
        o_item.font_size    = s_size;
        o_item.face_color   = s_face;
        o_item.border_color = s_border;
        o_item.alpha        = s_alpha;
        o_item.size_fault   = s_fault;

        unique case (s_phase)
            PH_DIGITS: begin
                n_acc  = {s_acc[11:0], hex_value(c)};
                n_left = (s_left != 3'd0) ? s_left - 3'd1 : 3'd0;
                if (n_left == 3'd0) begin
                    n_phase = PH_IDLE;
                    unique case (s_cmd)
                        CMD_I: begin
                            o_push           = 1'b1;
                            o_item.item_kind = ITEM_SPRITE;
                            o_item.item_code = n_acc;
                        end
                        CMD_A: n_alpha = n_acc[7:0];
                        CMD_S: begin
                            if (idx < {2'b00, i_cfg.font_count} && idx < 4'(SIZE_SLOTS)) begin
                                unique case (idx[1:0])
                                    2'd0:    n_size = i_cfg.size_map[2:0];
                                    2'd1:    n_size = i_cfg.size_map[5:3];
                                    2'd2:    n_size = i_cfg.size_map[8:6];
                                    default: n_size = s_size;
                                endcase
                            end else begin
                                n_fault = 1'b1;
                            end
                        end
                        CMD_F: n_face   = rgb_pack(n_acc[11:0]);
                        CMD_B: n_border = rgb_pack(n_acc[11:0]);
                        default: ;
                    endcase
                end
            end
            PH_HASH: begin
                n_phase = PH_DIGITS;
                n_acc   = 16'd0;
                priority if (c == CH_I) begin
                    n_cmd  = CMD_I;
                    n_left = 3'd4;
                end else if (c == CH_A) begin
                    n_cmd  = CMD_A;
                    n_left = 3'd2;
                end else if (c == CH_S) begin
                    n_cmd  = CMD_S;
                    n_left = 3'd1;
                end else if (c == CH_F) begin
                    n_cmd  = CMD_F;
                    n_left = 3'd3;
                end else if (c == CH_B) begin
                    n_cmd  = CMD_B;
                    n_left = 3'd3;
                end else begin
                    // Unknown letter: the hash is dropped and the letter decoded as text.
                    n_phase = PH_IDLE;
                    n_acc   = s_acc;
                    plain   = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase

        if (plain) begin
            if (c == CH_HASH) begin
                n_phase = PH_HASH;
            end else if (c != CH_CR) begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= CMD_I;
            r_left   <= 3'd0;
            r_acc    <= 16'd0;
            r_face   <= RST_START_FACE;
            r_border <= RST_START_BORDER;
            r_alpha  <= RST_START_ALPHA;
            r_size   <= RST_START_SIZE;
            r_fault  <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_left   <= n_left;
            r_acc    <= n_acc;
            r_face   <= n_face;
            r_border <= n_border;
            r_alpha  <= n_alpha;
            r_size   <= n_size;
            r_fault  <= n_fault;
        end
    end

    a_digits_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_left != 3'd0 && r_left <= 3'd4))
        else $error("digit phase without digits left");

    a_idle_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DIGITS) |-> (r_left == 3'd0))
        else $error("digits left outside digit phase");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_fault) && !$past(i_fire && i_item.text_start)) |-> r_fault)
        else $error("fault flag cleared without text start");

endmodule

`default_nettype wire

// ===== rtl/itmd_outq.sv =====
// Two-entry result queue between the parser and the output channel.
// Uses itmd_pkg for the result payload type.
`timescale 1ns / 1ps
`default_nettype none

module itmd_outq
    import itmd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("push into full result queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== test/inline_text_markup_decoder_tb.sv =====
// Self-checking bench for inline_text_markup_decoder: drives character beats, predicts glyph and
// sprite beats in step with accepted characters, and checks every output beat field by field.
// Depends on itmd_pkg and the RTL of inline_text_markup_decoder.
`timescale 1ns / 1ps

module inline_text_markup_decoder_tb;
    import itmd_pkg::*;

    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 3;
    localparam int TEXT_PHASES   = 7;

    typedef enum logic [1:0] {SCAN_PLAIN, SCAN_HASH, SCAN_DIGITS} scan_e;
    typedef enum logic [2:0] {MK_SPRITE, MK_ALPHA, MK_SIZE, MK_FACE, MK_BORDER} markup_e;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    inline_text_markup_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Characters waiting to be sent and draw beats the decoder still owes us.
    t_in_item  text_chars[$];
    t_out_item draw_items_due[$];
    t_out_item due_beat;

    // Register copies.
    logic [15:0] face_start, border_start;
    logic [7:0]  alpha_start;
    logic [2:0]  size_start;
    logic [1:0]  fonts_loaded;
    logic [8:0]  size_codes;

    // Decoder state as we predict it.
    scan_e       scan;
    markup_e     mark;
    int unsigned digits_due;
    logic [15:0] digit_acc;
    logic [15:0] face_cur, border_cur;
    logic [7:0]  alpha_cur;
    logic [2:0]  size_cur;
    logic        fault_cur;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_out_req = 1'b0;
    bit          rand_starts = 1'b0;
    int unsigned send_gap = 0;
    int unsigned rx_hold = 0;
    int unsigned errors = 0;
    int unsigned chars_accepted = 0;
    int unsigned glyphs_seen = 0;
    int unsigned sprites_seen = 0;
    int unsigned faults_seen = 0;
    int unsigned stalled_cycles = 0;
    int unsigned settings_used = 1;
    int          p;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [3:0] hex_nibble(input logic [15:0] c);
        if (c >= CH_0 && c <= CH_9) return 4'(c - CH_0);
        if (c >= CH_A && c <= CH_F) return 4'(c - CH_A + 16'd10);
        return 4'd0;
    endfunction

    function automatic logic [15:0] rgb565(input logic [11:0] v);
        return (16'(v[11:8]) << 12) | (16'(v[7:4]) << 7) | (16'(v[3:0]) << 1);
    endfunction

    task automatic restore_text_attrs();
        scan       = SCAN_PLAIN;
        mark       = MK_SPRITE;
        digits_due = 0;
        digit_acc  = '0;
        face_cur   = face_start;
        border_cur = border_start;
        alpha_cur  = alpha_start;
        size_cur   = size_start;
        fault_cur  = 1'b0;
    endtask

    task automatic load_register_defaults();
        face_start   = RST_START_FACE;
        border_start = RST_START_BORDER;
        alpha_start  = RST_START_ALPHA;
        size_start   = RST_START_SIZE;
        fonts_loaded = RST_FONT_COUNT;
        size_codes   = RST_SIZE_MAP;
        restore_text_attrs();
    endtask

    task automatic push_draw(input logic kind, input logic [15:0] code);
        t_out_item d;
        d.item_kind    = kind;
        d.item_code    = code;
        d.font_size    = size_cur;
        d.face_color   = face_cur;
        d.border_color = border_cur;
        d.alpha        = alpha_cur;
        d.size_fault   = fault_cur;
        draw_items_due.push_back(d);
    endtask

    task automatic decode_char(input t_in_item beat);
        logic [15:0] c;
        logic [3:0]  idx;
        int unsigned n;
        bit          taken;
        c = beat.char_code;
        taken = 1'b0;
        if (beat.text_start) restore_text_attrs();
        if (scan == SCAN_DIGITS) begin
            digit_acc = {digit_acc[11:0], hex_nibble(c)};
            digits_due--;
            if (digits_due == 0) begin
                scan = SCAN_PLAIN;
                case (mark)
                    MK_SPRITE: push_draw(ITEM_SPRITE, digit_acc);
                    MK_ALPHA:  alpha_cur = digit_acc[7:0];
                    MK_SIZE: begin
                        idx = digit_acc[3:0];
                        if (idx < {2'b00, fonts_loaded} && idx < 4'(SIZE_SLOTS)) begin
                            size_cur = size_codes[3*idx +: 3];
                        end else begin
                            fault_cur = 1'b1;
                        end
                    end
                    MK_FACE:   face_cur = rgb565(digit_acc[11:0]);
                    MK_BORDER: border_cur = rgb565(digit_acc[11:0]);
                    default: ;
                endcase
            end
        end else begin
            if (scan == SCAN_HASH) begin
                scan = SCAN_PLAIN;
                n = 0;
                if (c == CH_I) begin
                    mark = MK_SPRITE; n = 4;
                end else if (c == CH_A) begin
                    mark = MK_ALPHA; n = 2;
                end else if (c == CH_S) begin
                    mark = MK_SIZE; n = 1;
                end else if (c == CH_F) begin
                    mark = MK_FACE; n = 3;
                end else if (c == CH_B) begin
                    mark = MK_BORDER; n = 3;
                end
                if (n != 0) begin
                    scan = SCAN_DIGITS;
                    digits_due = n;
                    digit_acc = '0;
                    taken = 1'b1;
                end
            end
            // An unknown command letter falls through and is decoded as plain text.
            if (!taken) begin
                if (c == CH_HASH) begin
                    scan = SCAN_HASH;
                end else if (c != CH_CR) begin
                    push_draw(ITEM_GLYPH, c);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready === 1'b1) begin
                decode_char(i_in_item);
                chars_accepted++;
            end
            if (i_in_valid && o_in_ready !== 1'b1) stalled_cycles++;
            if (!i_in_valid || o_in_ready === 1'b1) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (text_chars.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= text_chars.pop_front();
                    send_gap   <= (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_hold     <= 0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (draw_items_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %h", $time, o_out_item);
                    errors++;
                end else begin
                    due_beat = draw_items_due.pop_front();
                    check_field("item_kind", 16'(due_beat.item_kind), 16'(o_out_item.item_kind));
                    check_field("item_code", due_beat.item_code, o_out_item.item_code);
                    check_field("font_size", 16'(due_beat.font_size), 16'(o_out_item.font_size));
                    check_field("face_color", due_beat.face_color, o_out_item.face_color);
                    check_field("border_color", due_beat.border_color,
                                o_out_item.border_color);
                    check_field("alpha", 16'(due_beat.alpha), 16'(o_out_item.alpha));
                    check_field("size_fault", 16'(due_beat.size_fault),
                                16'(o_out_item.size_fault));
                    if (due_beat.item_kind == ITEM_SPRITE) sprites_seen++;
                    else glyphs_seen++;
                    if (due_beat.size_fault) faults_seen++;
                end
            end
            if (rx_hold > 0) begin
                rx_hold     <= rx_hold - 1;
                i_out_ready <= 1'b0;
            end else if (hold_out_req) begin
                hold_out_req = 1'b0;
                rx_hold     <= LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                rx_hold     <= pick_len() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_char(input logic [15:0] c, input bit start);
        t_in_item beat;
        beat.char_code  = c;
        beat.text_start = start | (rand_starts && $urandom_range(0, 49) == 0);
        text_chars.push_back(beat);
    endtask

    function automatic logic [15:0] hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        return (v < 10) ? CH_0 + 16'(v) : CH_A + 16'(v - 10);
    endfunction

    // Mostly valid digits; the rest are characters that almost always count as zero.
    function automatic logic [15:0] digit_char();
        case ($urandom_range(0, 19))
            0: return CH_HASH;
            1: return CH_CR;
            2: return 16'h0061 + 16'($urandom_range(0, 5));
            3: return 16'($urandom);
            default: return hex_char();
        endcase
    endfunction

    function automatic logic [15:0] plain_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(16'h0020, 16'h007E));
        if (r < 90) return 16'($urandom);
        return CH_CR;
    endfunction

    task automatic queue_text(input int unsigned n, input bit first_start);
        int unsigned k, ndig;
        logic [15:0] letter;
        int unsigned r;
        rand_starts = 1'b0;
        add_char(plain_char(), first_start);
        rand_starts = 1'b1;
        k = text_chars.size();
        while (text_chars.size() < k + n) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_char(plain_char(), 1'b0);
            end else if (r < 80) begin
                case ($urandom_range(0, 4))
                    0: begin letter = CH_I; ndig = 4; end
                    1: begin letter = CH_A; ndig = 2; end
                    2: begin letter = CH_S; ndig = 1; end
                    3: begin letter = CH_F; ndig = 3; end
                    default: begin letter = CH_B; ndig = 3; end
                endcase
                add_char(CH_HASH, 1'b0);
                add_char(letter, 1'b0);
                repeat (ndig) begin
                    // Size indexes cluster near the font count so both outcomes show up.
                    if (letter == CH_S && $urandom_range(0, 1) == 1) begin
                        add_char(CH_0 + 16'($urandom_range(0, 3)), 1'b0);
                    end else begin
                        add_char(digit_char(), 1'b0);
                    end
                end
            end else if (r < 90) begin
                add_char(CH_HASH, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    add_char(plain_char(), 1'b0);
                end else begin
                    add_char(CH_F, 1'b0);
                    add_char(hex_char(), 1'b0);
                    add_char(plain_char(), 1'b1);
                end
            end else begin
                add_char(16'($urandom), 1'b0);
            end
        end
    endtask

    // Returns at a falling edge once nothing is in flight in either direction.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (text_chars.size() != 0 || i_in_valid || draw_items_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_START_FACE:   face_start = val;
            REG_START_BORDER: border_start = val;
            REG_START_ALPHA:  alpha_start = val[7:0];
            REG_START_SIZE:   size_start = val[2:0];
            REG_FONT_COUNT:   fonts_loaded = val[1:0];
            REG_SIZE_MAP:     size_codes = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] face, input logic [15:0] border,
                                  input logic [7:0] alpha, input logic [2:0] size,
                                  input logic [1:0] count, input logic [8:0] smap);
        write_reg(REG_START_FACE, face);
        write_reg(REG_START_BORDER, border);
        write_reg(REG_START_ALPHA, 16'(alpha));
        write_reg(REG_START_SIZE, 16'(size));
        write_reg(REG_FONT_COUNT, 16'(count));
        write_reg(REG_SIZE_MAP, 16'(smap));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin
        load_register_defaults();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed text under the reset register values.
        add_char(16'("H"), 1'b1);
        add_char(16'hFFFF, 1'b0);
        add_char(16'h0000, 1'b0);
        add_char(CH_CR, 1'b0);
        add_char(CH_HASH, 1'b0); add_char(CH_I, 1'b0);
        add_char(16'("0"), 1'b0); add_char(16'("9"), 1'b0);
        add_char(16'("A"), 1'b0); add_char(16'("F"), 1'b0);
        // A lower-case letter is not a hex digit.
        add_char(CH_HASH, 1'b0); add_char(CH_A, 1'b0);
        add_char(16'("a"), 1'b0); add_char(16'("7"), 1'b0);
        add_char(CH_HASH, 1'b0); add_char(CH_S, 1'b0); add_char(16'("2"), 1'b0);
        add_char(CH_HASH, 1'b0); add_char(CH_S, 1'b0); add_char(16'("F"), 1'b0);
        add_char(CH_HASH, 1'b0); add_char(CH_B, 1'b0);
        add_char(CH_HASH, 1'b0); add_char(CH_CR, 1'b0); add_char(16'("E"), 1'b0);
        add_char(CH_HASH, 1'b0); add_char(16'("Z"), 1'b0);
        // A text start in the middle of a color sequence abandons it.
        add_char(CH_HASH, 1'b0); add_char(CH_F, 1'b0); add_char(16'("1"), 1'b1);

        for (p = 0; p < TEXT_PHASES; p++) begin
            wait_idle();
            case (p)
                0: apply_settings(16'h0000, 16'h0000, 8'h00, 3'd0, 2'd1, 9'd0);
                1: apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 3'd7, 2'd3, 9'h1FF);
                default: apply_settings(16'($urandom), 16'($urandom), 8'($urandom),
                                        3'($urandom), 2'($urandom_range(1, 3)),
                                        9'($urandom));
            endcase
            tx_idle_on = (p < 1 || p > 3);
            rx_idle_on = (p != 3);
            if (p == 2) hold_out_req = 1'b1;
            if (p == 4) begin
                queue_text(100, 1'b1);
                wait_idle();
                queue_text(105, 1'b0);
            end else begin
                queue_text(205, p[0]);
            end
        end

        wait_idle();
        $display("Summary: %0d characters gave %0d glyphs and %0d sprites under %0d settings.",
                 chars_accepted, glyphs_seen, sprites_seen, settings_used);
        $display("Input held off %0d cycles by back-pressure; %0d beats carried a size fault.",
                 stalled_cycles, faults_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== inline_text_markup_decoder.f =====
rtl/itmd_pkg.sv
rtl/itmd_cfg.sv
rtl/itmd_parse.sv
rtl/itmd_outq.sv
rtl/inline_text_markup_decoder.sv
test/inline_text_markup_decoder_tb.sv
